### rtl/core/minv_pkg.sv
// ----------------------------------------------------------------------------
// minv_pkg : shared types and constants for the 3x3 matrix inverse
//
// Channel payloads, datapath widths and the lane record that travels down
// the reciprocal and scaling stages.
// ----------------------------------------------------------------------------
package minv_pkg;

   localparam int IN_W      = 24;  // input element width
   localparam int OUT_W     = 32;  // output element width
   localparam int COF_W     = 48;  // exact 2x2 cofactor
   localparam int HALF_W    = 24;  // half of a cofactor for split multiplies
   localparam int DET_W     = 73;  // exact determinant, signed
   localparam int MAG_W     = 72;  // determinant magnitude
   localparam int REM_W     = 73;  // divider partial remainder
   localparam int Q_W       = 33;  // reciprocal width
   localparam int DIV_STEPS = 33;  // one quotient bit per stage
   localparam int SH_W      = 7;   // output alignment shift
   localparam int PP_W      = 56;  // 24 x 32 partial product
   localparam int PROD_W    = 80;  // |cofactor| * reciprocal
   localparam int WIDE_W    = 97;  // product with guard bits for rounding
   localparam int RES_W     = 96;  // rounded magnitude before clamping
   localparam int NUM_EL    = 9;

   typedef struct packed {
      logic signed [IN_W-1:0] m00;
      logic signed [IN_W-1:0] m01;
      logic signed [IN_W-1:0] m02;
      logic signed [IN_W-1:0] m10;
      logic signed [IN_W-1:0] m11;
      logic signed [IN_W-1:0] m12;
      logic signed [IN_W-1:0] m20;
      logic signed [IN_W-1:0] m21;
      logic signed [IN_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] inv00;
      logic signed [OUT_W-1:0] inv01;
      logic signed [OUT_W-1:0] inv02;
      logic signed [OUT_W-1:0] inv10;
      logic signed [OUT_W-1:0] inv11;
      logic signed [OUT_W-1:0] inv12;
      logic signed [OUT_W-1:0] inv20;
      logic signed [OUT_W-1:0] inv21;
      logic signed [OUT_W-1:0] inv22;
      logic                    singular;
      logic                    saturated;
   } rsp_type;

   // per-item record carried past the determinant: adjugate magnitudes in
   // output order, result signs, alignment shift and the singular flag
   typedef struct packed {
      logic [NUM_EL-1:0][COF_W-1:0] cmag;
      logic [NUM_EL-1:0]            neg;
      logic [SH_W-1:0]              sh;
      logic                         singular;
   } lane_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [Q_W-1:0]   q;
      logic [MAG_W-1:0] dn;
      lane_type         lane;
   } div_type;

endpackage

### rtl/core/minv_channels.sv
// ----------------------------------------------------------------------------
// minv channels : valid/ready channel interfaces
//
// Request channel carries one matrix, response channel one inverse.
// ----------------------------------------------------------------------------
interface minv_req_if;
   import minv_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface minv_rsp_if;
   import minv_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/matrix3x3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse : pipelined fixed-point 3x3 inverse by the adjugate
//
// req_if takes one matrix of nine signed Q8.16 elements per transfer; rsp_if
// returns nine signed Q16.16 elements, saturated, with singular and
// saturated flags. One result per request, in order.
// The pipeline has 47 register stages. Most of that depth is the 33-stage
// restoring divider for the determinant reciprocal, one quotient bit per
// stage. A new matrix can be taken every cycle unless every stage is full
// and rsp_if.ready is low.
// Each stage holds its item until the next stage is empty or moving, so
// when rsp_if.ready is low the pipeline fills its bubbles and keeps taking
// requests until every stage is occupied; nothing is dropped or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
// A zero determinant gives all-zero elements, singular set, saturated clear.
// FRAC_BITS (8..24) sets the fraction width of both inputs and outputs.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
   parameter int FRAC_BITS = 16
) (
   input logic          clock,
   input logic          reset,
   minv_req_if.sink     req_if,
   minv_rsp_if.source   rsp_if
);
   import minv_pkg::*;

   localparam int ST_PROD = 0;
   localparam int ST_COF  = 1;
   localparam int ST_EXP  = 2;
   localparam int ST_TERM = 3;
   localparam int ST_DET  = 4;
   localparam int ST_ABS  = 5;
   localparam int ST_NRM1 = 6;
   localparam int ST_NRM2 = 7;
   localparam int ST_DIV0 = 8;
   localparam int ST_MUL1 = ST_DIV0 + DIV_STEPS;
   localparam int ST_MUL2 = ST_MUL1 + 1;
   localparam int ST_SHC  = ST_MUL2 + 1;
   localparam int ST_SHF  = ST_SHC + 1;
   localparam int ST_RND  = ST_SHF + 1;
   localparam int ST_OUT  = ST_RND + 1;
   localparam int NST     = ST_OUT + 1;
   // alignment shift = SH_BASE - leading zeros of |det|
   localparam int SH_BASE = 119 - 2 * FRAC_BITS;

   // ---------------------------------------------------------------
   // stage valids and enables: a stage loads when empty or draining
   // ---------------------------------------------------------------
   logic [NST-1:0] v_ff, v_in, en;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_if.ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in = (en & {v_ff[NST-2:0], req_if.valid}) | (~en & v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_if.ready = en[ST_PROD];
   assign rsp_if.valid = v_ff[ST_OUT];

   // ---------------------------------------------------------------
   // products for the cofactors
   // ---------------------------------------------------------------
   logic signed [IN_W-1:0]  e [3][3];
   logic signed [COF_W-1:0] pa_in [3][3], pa_ff [3][3];
   logic signed [COF_W-1:0] pb_in [3][3], pb_ff [3][3];
   logic signed [IN_W-1:0]  row_p_ff [3], row_c_ff [3];

   assign e[0][0] = req_if.data.m00;
   assign e[0][1] = req_if.data.m01;
   assign e[0][2] = req_if.data.m02;
   assign e[1][0] = req_if.data.m10;
   assign e[1][1] = req_if.data.m11;
   assign e[1][2] = req_if.data.m12;
   assign e[2][0] = req_if.data.m20;
   assign e[2][1] = req_if.data.m21;
   assign e[2][2] = req_if.data.m22;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            pa_in[r][c] = e[(r+1)%3][(c+1)%3] * e[(r+2)%3][(c+2)%3];
            pb_in[r][c] = e[(r+1)%3][(c+2)%3] * e[(r+2)%3][(c+1)%3];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_PROD]) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         row_p_ff <= e[0];
      end
   end

   // ---------------------------------------------------------------
   // cofactors
   // ---------------------------------------------------------------
   logic signed [COF_W-1:0] cof_in [3][3], cof_c_ff [3][3];
   logic signed [COF_W-1:0] cof_e_ff [3][3], cof_t_ff [3][3], cof_d_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            cof_in[r][c] = pa_ff[r][c] - pb_ff[r][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_COF]) begin
         cof_c_ff <= cof_in;
         row_c_ff <= row_p_ff;
      end
   end

   // ---------------------------------------------------------------
   // row 0 expansion, cofactor split into high and low halves
   // ---------------------------------------------------------------
   logic signed [COF_W:0]   plo_in [3], plo_ff [3];
   logic signed [COF_W-1:0] phi_in [3], phi_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         plo_in[c] = row_c_ff[c] * $signed({1'b0, cof_c_ff[0][c][HALF_W-1:0]});
         phi_in[c] = row_c_ff[c] * $signed(cof_c_ff[0][c][COF_W-1:HALF_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_EXP]) begin
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         cof_e_ff <= cof_c_ff;
      end
   end

   // recombine the halves
   logic signed [DET_W-1:0] term_in [3], term_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         term_in[c] = (DET_W'(phi_ff[c]) <<< HALF_W) + DET_W'(plo_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_TERM]) begin
         term_ff  <= term_in;
         cof_t_ff <= cof_e_ff;
      end
   end

   // determinant
   logic signed [DET_W-1:0] det_ff;

   always_ff @(posedge clock) begin
      if (en[ST_DET]) begin
         det_ff   <= term_ff[0] + term_ff[1] + term_ff[2];
         cof_d_ff <= cof_t_ff;
      end
   end

   // ---------------------------------------------------------------
   // magnitudes, signs and the adjugate in output order
   // ---------------------------------------------------------------
   logic [MAG_W-1:0]     dabs_in, dabs_ff;
   logic [DET_W-1:0]     dneg_val;
   logic [COF_W-1:0]     cneg_val;
   lane_type             lane_a_in, lane_a_ff;

   always_comb begin
      dneg_val  = -det_ff;
      dabs_in   = det_ff[DET_W-1] ? dneg_val[MAG_W-1:0] : det_ff[MAG_W-1:0];
      lane_a_in = '0;
      lane_a_in.singular = (det_ff == '0);
      cneg_val  = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cneg_val = -cof_d_ff[j][i];
            lane_a_in.cmag[i*3+j] = cof_d_ff[j][i][COF_W-1] ? cneg_val : cof_d_ff[j][i];
            lane_a_in.neg[i*3+j]  = cof_d_ff[j][i][COF_W-1] ^ det_ff[DET_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_ABS]) begin
         dabs_ff   <= dabs_in;
         lane_a_ff <= lane_a_in;
      end
   end

   // ---------------------------------------------------------------
   // normalise |det| so its leading one sits at the top bit
   // ---------------------------------------------------------------
   logic [MAG_W-1:0] nx1_in, nx1_ff, nx2_in, nx2_ff;
   logic [SH_W-1:0]  nz1_in, nz1_ff, nz2_in;
   lane_type         lane_n1_ff, lane_n2_in, lane_n2_ff;

   // coarse steps: 64, 32, 16, 8
   always_comb begin
      nx1_in = dabs_ff;
      nz1_in = '0;
      if (nx1_in[MAG_W-1:8] == '0) begin
         nx1_in    = nx1_in << 64;
         nz1_in[6] = 1'b1;
      end
      if (nx1_in[MAG_W-1:40] == '0) begin
         nx1_in    = nx1_in << 32;
         nz1_in[5] = 1'b1;
      end
      if (nx1_in[MAG_W-1:56] == '0) begin
         nx1_in    = nx1_in << 16;
         nz1_in[4] = 1'b1;
      end
      if (nx1_in[MAG_W-1:64] == '0) begin
         nx1_in    = nx1_in << 8;
         nz1_in[3] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_NRM1]) begin
         nx1_ff     <= nx1_in;
         nz1_ff     <= nz1_in;
         lane_n1_ff <= lane_a_ff;
      end
   end

   // fine steps: 4, 2, 1; alignment shift from the leading-zero count
   always_comb begin
      nx2_in = nx1_ff;
      nz2_in = nz1_ff;
      if (nx2_in[MAG_W-1:68] == '0) begin
         nx2_in    = nx2_in << 4;
         nz2_in[2] = 1'b1;
      end
      if (nx2_in[MAG_W-1:70] == '0) begin
         nx2_in    = nx2_in << 2;
         nz2_in[1] = 1'b1;
      end
      if (!nx2_in[MAG_W-1]) begin
         nx2_in    = nx2_in << 1;
         nz2_in[0] = 1'b1;
      end
      lane_n2_in    = lane_n1_ff;
      lane_n2_in.sh = SH_W'(SH_BASE) - nz2_in;
   end

   always_ff @(posedge clock) begin
      if (en[ST_NRM2]) begin
         nx2_ff     <= nx2_in;
         lane_n2_ff <= lane_n2_in;
      end
   end

   // ---------------------------------------------------------------
   // restoring divider: one reciprocal bit per stage
   // ---------------------------------------------------------------
   div_type          div_in [DIV_STEPS], div_ff [DIV_STEPS];
   div_type          div_src;
   logic             div_ge;
   logic [REM_W-1:0] div_diff;

   always_comb begin
      div_src  = '0;
      div_ge   = 1'b0;
      div_diff = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (j == 0) begin
            div_src.rem  = REM_W'(1) << (MAG_W - 1);
            div_src.q    = '0;
            div_src.dn   = nx2_ff;
            div_src.lane = lane_n2_ff;
         end else begin
            div_src = div_ff[j-1];
         end
         div_ge   = div_src.rem >= {1'b0, div_src.dn};
         div_diff = div_src.rem - {1'b0, div_src.dn};
         div_in[j]     = div_src;
         div_in[j].q   = {div_src.q[Q_W-2:0], div_ge};
         div_in[j].rem = div_ge ? {div_diff[REM_W-2:0], 1'b0}
                                : {div_src.rem[REM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (en[ST_DIV0+j]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // ---------------------------------------------------------------
   // scale adjugate by the reciprocal: 24 x 32 partial products
   // ---------------------------------------------------------------
   div_type          recip;
   logic [PP_W-1:0]  pl_in [NUM_EL], pl_ff [NUM_EL];
   logic [PP_W-1:0]  ph_in [NUM_EL], ph_ff [NUM_EL];
   logic             rbig_ff;
   lane_type         lane_m1_ff;

   assign recip = div_ff[DIV_STEPS-1];

   always_comb begin
      for (int n = 0; n < NUM_EL; n++) begin
         pl_in[n] = PP_W'(recip.lane.cmag[n][HALF_W-1:0]) * PP_W'(recip.q[Q_W-2:0]);
         ph_in[n] = PP_W'(recip.lane.cmag[n][COF_W-1:HALF_W]) * PP_W'(recip.q[Q_W-2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL1]) begin
         pl_ff      <= pl_in;
         ph_ff      <= ph_in;
         rbig_ff    <= recip.q[Q_W-1];
         lane_m1_ff <= recip.lane;
      end
   end

   // sum partials; a reciprocal of exactly 2^32 is a plain shift
   logic [PROD_W-1:0] prod_in [NUM_EL], prod_ff [NUM_EL];
   lane_type          lane_m2_ff;

   always_comb begin
      for (int n = 0; n < NUM_EL; n++) begin
         if (rbig_ff) begin
            prod_in[n] = {lane_m1_ff.cmag[n], 32'b0};
         end else begin
            prod_in[n] = (PROD_W'(ph_ff[n]) << HALF_W) + PROD_W'(pl_ff[n]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL2]) begin
         prod_ff    <= prod_in;
         lane_m2_ff <= lane_m1_ff;
      end
   end

   // ---------------------------------------------------------------
   // alignment: product with one guard bit, right shift in two steps
   // ---------------------------------------------------------------
   logic [WIDE_W-1:0] shc_in [NUM_EL], shc_ff [NUM_EL];
   logic [WIDE_W-1:0] shf_in [NUM_EL], shf_ff [NUM_EL];
   lane_type          lane_shc_ff, lane_shf_ff;

   always_comb begin
      for (int n = 0; n < NUM_EL; n++) begin
         shc_in[n] = {prod_ff[n], 17'b0} >> {lane_m2_ff.sh[SH_W-1:4], 4'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SHC]) begin
         shc_ff      <= shc_in;
         lane_shc_ff <= lane_m2_ff;
      end
   end

   always_comb begin
      for (int n = 0; n < NUM_EL; n++) begin
         shf_in[n] = shc_ff[n] >> lane_shc_ff.sh[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SHF]) begin
         shf_ff      <= shf_in;
         lane_shf_ff <= lane_shc_ff;
      end
   end

   // round half away from zero on the magnitude
   logic [WIDE_W-1:0] rsum [NUM_EL];
   logic [RES_W-1:0]  res_in [NUM_EL], res_ff [NUM_EL];
   lane_type          lane_rnd_ff;

   always_comb begin
      for (int n = 0; n < NUM_EL; n++) begin
         rsum[n]   = shf_ff[n] + WIDE_W'(1);
         res_in[n] = rsum[n][WIDE_W-1:1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_RND]) begin
         res_ff      <= res_in;
         lane_rnd_ff <= lane_shf_ff;
      end
   end

   // ---------------------------------------------------------------
   // clamp, apply sign, output register
   // ---------------------------------------------------------------
   logic [OUT_W-1:0] lim, mag;
   logic [OUT_W-1:0] el [NUM_EL];
   logic [NUM_EL-1:0] over;
   rsp_type           out_in, out_ff;

   always_comb begin
      lim = '0;
      mag = '0;
      for (int n = 0; n < NUM_EL; n++) begin
         lim     = lane_rnd_ff.neg[n] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         over[n] = (res_ff[n][RES_W-1:OUT_W] != '0) || (res_ff[n][OUT_W-1:0] > lim);
         mag     = over[n] ? lim : res_ff[n][OUT_W-1:0];
         el[n]   = lane_rnd_ff.singular ? '0 : (lane_rnd_ff.neg[n] ? -mag : mag);
      end
      out_in.inv00     = el[0];
      out_in.inv01     = el[1];
      out_in.inv02     = el[2];
      out_in.inv10     = el[3];
      out_in.inv11     = el[4];
      out_in.inv12     = el[5];
      out_in.inv20     = el[6];
      out_in.inv21     = el[7];
      out_in.inv22     = el[8];
      out_in.singular  = lane_rnd_ff.singular;
      out_in.saturated = (|over) && !lane_rnd_ff.singular;
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.data = out_ff;

endmodule

### tb/sv/matrix3x3_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_checker : scoreboard for the 3x3 matrix inverse
//
// Watches both channels. Each request transfer is run through a bit-exact
// adjugate inverse and the outcome queued; each response transfer is
// compared field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_checker
   import minv_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input logic       clock,
   input logic       reset,
   minv_req_if.sink  req_mon,
   minv_rsp_if.sink  rsp_mon,
   output int        fail_count,
   output int        inv_pending
);

   localparam int RECIP_BITS = 32;

   rsp_type inverse_q[$];

   assign inv_pending = inverse_q.size();

   // print one mismatch line and count it
   task automatic report(input string what);
      $display("%0t: mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // exact adjugate inverse with a normalised determinant reciprocal
   function automatic rsp_type invert(input req_type m);
      logic signed [IN_W-1:0]   e [3][3];
      logic signed [COF_W-1:0]  cof [3][3];
      logic signed [127:0]      det;
      logic [127:0]             dabs, rem, v, lim;
      logic [32:0]              recip;
      logic signed [31:0]       el [9];
      logic                     dneg, neg, sat;
      int                       lead, sh;
      rsp_type                  r;
      e[0][0] = m.m00; e[0][1] = m.m01; e[0][2] = m.m02;
      e[1][0] = m.m10; e[1][1] = m.m11; e[1][2] = m.m12;
      e[2][0] = m.m20; e[2][1] = m.m21; e[2][2] = m.m22;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            cof[a][b] = 48'(128'(e[(a+1)%3][(b+1)%3]) * 128'(e[(a+2)%3][(b+2)%3])
                      - 128'(e[(a+1)%3][(b+2)%3]) * 128'(e[(a+2)%3][(b+1)%3]));
      det = 0;
      for (int b = 0; b < 3; b++)
         det += 128'(e[0][b]) * 128'(cof[0][b]);
      r = '0;
      sat = 1'b0;
      if (det == 0) begin
         r.singular = 1'b1;
         return r;
      end
      dneg = det < 0;
      dabs = dneg ? -det : det;
      lead = 0;
      for (int k = 0; k < 128; k++)
         if (dabs[k]) lead = k;
      rem = 128'd1 << lead;
      recip = '0;
      for (int k = 0; k <= RECIP_BITS; k++) begin
         recip = recip << 1;
         if (rem >= dabs) begin
            rem = rem - dabs;
            recip[0] = 1'b1;
         end
         rem = rem << 1;
      end
      sh = 2 * FRAC_BITS - lead - RECIP_BITS;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            if (cof[j][i] == 0) begin
               el[i*3+j] = 0;
               continue;
            end
            neg = (cof[j][i] < 0) != dneg;
            v = (cof[j][i] < 0) ? 128'(-128'(cof[j][i])) : 128'(cof[j][i]);
            v = v * 128'(recip);
            if (sh >= 0) v = v << sh;
            else v = (v + (128'd1 << (-sh - 1))) >> (-sh);
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (v > lim) begin
               sat = 1'b1;
               v = lim;
            end
            el[i*3+j] = neg ? -v[31:0] : v[31:0];
         end
      r.inv00 = el[0]; r.inv01 = el[1]; r.inv02 = el[2];
      r.inv10 = el[3]; r.inv11 = el[4]; r.inv12 = el[5];
      r.inv20 = el[6]; r.inv21 = el[7]; r.inv22 = el[8];
      r.saturated = sat;
      return r;
   endfunction

   // predict on request transfers, compare on response transfers
   always @(posedge clock) begin
      rsp_type want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            inverse_q.insert(inverse_q.size(), invert(req_mon.data));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (inverse_q.size() == 0) begin
               report("response with nothing expected");
            end else begin
               want = inverse_q.pop_front();
               if (got.inv00 !== want.inv00) report($sformatf("inv00 %h want %h", got.inv00, want.inv00));
               if (got.inv01 !== want.inv01) report($sformatf("inv01 %h want %h", got.inv01, want.inv01));
               if (got.inv02 !== want.inv02) report($sformatf("inv02 %h want %h", got.inv02, want.inv02));
               if (got.inv10 !== want.inv10) report($sformatf("inv10 %h want %h", got.inv10, want.inv10));
               if (got.inv11 !== want.inv11) report($sformatf("inv11 %h want %h", got.inv11, want.inv11));
               if (got.inv12 !== want.inv12) report($sformatf("inv12 %h want %h", got.inv12, want.inv12));
               if (got.inv20 !== want.inv20) report($sformatf("inv20 %h want %h", got.inv20, want.inv20));
               if (got.inv21 !== want.inv21) report($sformatf("inv21 %h want %h", got.inv21, want.inv21));
               if (got.inv22 !== want.inv22) report($sformatf("inv22 %h want %h", got.inv22, want.inv22));
               if (got.singular !== want.singular)
                  report($sformatf("singular %b want %b", got.singular, want.singular));
               if (got.saturated !== want.saturated)
                  report($sformatf("saturated %b want %b", got.saturated, want.saturated));
            end
         end
      end
   end

endmodule

### tb/sv/matrix3x3_inverse_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb : stimulus and verdict for the 3x3 matrix inverse
//
// Directed matrices (identity, singular, extremes, saturating) then random
// ones of mixed magnitude, under three idling mixes and a long response
// hold-off; the checker does the predicting and comparing.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_tb;
   import minv_pkg::*;

   localparam int LATENCY   = 47;
   localparam int WATCH_MAX = 20000;
   localparam int N_RANDOM  = 1080;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, inv_pending, send_pct, stall_pct, idle_run;
   bit   hold_rsp = 1'b0;

   minv_req_if req_if ();
   minv_rsp_if rsp_if ();

   always #6 clock = ~clock;

   matrix3x3_inverse DUT (.clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if));

   matrix3x3_inverse_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_if), .rsp_mon(rsp_if),
      .fail_count(fail_count), .inv_pending(inv_pending));

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
   end

   // receiver: random stalls unless held off
   always @(posedge clock)
      rsp_if.ready <= !reset && !hold_rsp && ($urandom_range(99) >= stall_pct);

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         idle_run <= 0;
      else if (idle_run >= WATCH_MAX) begin
         $display("watchdog expired");
         $display("matrix3x3_inverse_tb failed");
         $finish;
      end else
         idle_run <= idle_run + 1;
   end

   function automatic logic [IN_W-1:0] rand_el();
      case ($urandom_range(5))
         0: return IN_W'($urandom);
         1: return IN_W'($signed($urandom_range(511)) - 256) <<< 16;
         2: return IN_W'($signed($urandom_range(2047)) - 1024);
         3: return ($urandom_range(1)) ? 24'h7FFFFF : 24'h800000;
         4: return 24'h0;
         default: return IN_W'($signed($urandom_range(131071)) - 65536) <<< $urandom_range(7);
      endcase
   endfunction

   // present one matrix and hold it until transferred; valid is left high,
   // the next send or drain settles it in the same time step
   task automatic send(input req_type m);
      while ($urandom_range(99) < send_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= m;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_diag(input logic [IN_W-1:0] a, b, c);
      req_type m;
      m = '0;
      m.m00 = a; m.m11 = b; m.m22 = c;
      send(m);
   endtask

   task automatic send_random();
      req_type m;
      m = {rand_el(), rand_el(), rand_el(), rand_el(), rand_el(),
           rand_el(), rand_el(), rand_el(), rand_el()};
      if ($urandom_range(9) == 0) begin
         m.m20 = m.m10; m.m21 = m.m11; m.m22 = m.m12;
      end
      send(m);
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (inv_pending != 0) @(posedge clock);
   endtask

   initial begin
      req_type m;
      send_pct = 13;
      stall_pct = 80;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed matrices
      send_diag(24'h010000, 24'h010000, 24'h010000);
      send_diag(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_diag(24'h800000, 24'h800000, 24'h800000);
      send_diag(24'h000001, 24'h000001, 24'h000001);
      send_diag(24'h000001, 24'h7FFFFF, 24'h800000);
      send_diag(24'hFFFFFF, 24'h020000, 24'h008000);
      send_diag(24'h0, 24'h010000, 24'h010000);
      send('0);
      send({9{24'h7FFFFF}});
      send({9{24'h800000}});
      send({9{24'hFFFFFF}});
      send({9{24'h555555}});
      send({9{24'hAAAAAA}});
      m = '0;
      m.m02 = 24'h010000; m.m11 = 24'hFF0000; m.m20 = 24'h030000;
      send(m);
      m = {24'h7FFFFF, 24'h800000, 24'h000001, 24'h123456, 24'hEDCBA9,
           24'h0F0F0F, 24'hF0F0F0, 24'h3C3C3C, 24'hC3C3C3};
      send(m);
      m = {24'h020000, 24'h010000, 24'h0, 24'h010000, 24'h020000,
           24'h010000, 24'h0, 24'h010000, 24'h020000};
      send(m);

      // random matrices under three idling mixes
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            send_pct = 80;
            stall_pct = 13;
         end else if (n == 2 * N_RANDOM / 3) begin
            send_pct = 0;
            stall_pct = 0;
         end
         if (n == N_RANDOM / 2) drain();
         send_random();
      end
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("matrix3x3_inverse_tb passed");
      else
         $display("matrix3x3_inverse_tb failed");
      $finish;
   end

   // long response hold-off while requests keep coming, to fill the pipeline
   initial begin
      wait (!reset);
      repeat (1000) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (600) @(posedge clock);
      hold_rsp <= 1'b0;
   end

endmodule
